// ===== sv/scrolling_display_marquee_defines.svh =====
// assertion macros for the scrolling display marquee
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef SCROLLING_DISPLAY_MARQUEE_DEFINES_SVH
`define SCROLLING_DISPLAY_MARQUEE_DEFINES_SVH

// checked while out of reset
`define SDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define SDM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== sv/sdm_pkg.sv =====
// shared constants, codes and types of the scrolling display marquee
// no dependencies
`default_nettype none

package sdm_pkg;

    localparam int DIGITS    = 8;
    localparam int MSG_DEPTH = 256;
    localparam int ADDR_W    = $clog2(MSG_DEPTH);
    localparam int LEN_W     = 9;
    localparam int IDX_W     = 10;
    localparam int TIMER_W   = 16;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 3;
    localparam int DIR_W     = 2;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_INTERVAL  = 1'b1;

    typedef enum logic [2:0] {
        M_IDLE  = 3'b001,
        M_RESET = 3'b010,
        M_RUN   = 3'b100
    } t_mode;

    typedef struct packed {
        logic clear;
        logic shift_l;
        logic shift_r;
        logic load;
        logic drain;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== sv/sdm_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/sdm_cell.sv =====
// one display cell with its output snapshot cell
// depends on sdm_pkg
`default_nettype none

module sdm_cell (
    input  wire logic                          i_clk,
    input  wire sdm_pkg::t_cell_ctl            i_ctl,
    input  wire logic [sdm_pkg::CHAR_W-1:0]    i_from_left,
    input  wire logic [sdm_pkg::CHAR_W-1:0]    i_from_right,
    input  wire logic [sdm_pkg::CHAR_W-1:0]    i_out_from_right,
    output logic      [sdm_pkg::CHAR_W-1:0]    o_disp,
    output logic      [sdm_pkg::CHAR_W-1:0]    o_out
);

    logic [sdm_pkg::CHAR_W-1:0] r_disp;
    logic [sdm_pkg::CHAR_W-1:0] n_disp;
    logic [sdm_pkg::CHAR_W-1:0] r_out;
    logic [sdm_pkg::CHAR_W-1:0] n_out;

    always_comb begin
        priority if (i_ctl.clear) begin
            n_disp = '0;
        end else if (i_ctl.shift_l) begin
            n_disp = i_from_right;
        end else if (i_ctl.shift_r) begin
            n_disp = i_from_left;
        end else begin
            n_disp = r_disp;
        end
    end

    always_comb begin
        priority if (i_ctl.load) begin
            n_out = n_disp;
        end else if (i_ctl.drain) begin
            n_out = i_out_from_right;
        end else begin
            n_out = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_disp <= n_disp;
        r_out  <= n_out;
    end

    assign o_disp = r_disp;
    assign o_out  = r_out;

endmodule

`default_nettype wire

// ===== sv/scrolling_display_marquee.sv =====
// top level of the scrolling display marquee: control, message ram, cell row
// depends on sdm_pkg, sdm_ram, sdm_cell and scrolling_display_marquee_defines.svh
//
// channel   dir  handshake            payload
// s         in   i_s_tvalid/o_s_tready  tdata: operation, address, value, length
// m         out  o_m_tvalid/i_m_tready  tdata: position, character; tlast: last
// cfg       in   psel/penable/pwrite    direction @0x0, interval_ticks @0x4
//
// a firing tick reads the message ram as it is taken, is registered, shifts the
// cell row once the output row is free and drains 8 results, one per cycle while
// i_m_tready is high; it holds the output cell row until the drain chain ends
// reset is synchronous; mode, timer, index, length and handshake state are cleared
// o_s_tready drops only while a firing tick waits for the output row to empty
`default_nettype none
`include "scrolling_display_marquee_defines.svh"

module scrolling_display_marquee (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [1:0] operation, [9:2] address, [17:10] value, [26:18] length, [31:27] zero
    input  wire logic [31:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [2:0] position, [10:3] character, [15:11] zero
    output logic      [15:0] o_m_tdata,
    output logic             o_m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    typedef struct packed {
        logic                       fire;
        logic                       clear;
        logic                       zero;
        logic [sdm_pkg::DIR_W-1:0]  dir;
    } t_s2;

    // configuration
    logic [sdm_pkg::DIR_W-1:0]   r_dir;
    logic [sdm_pkg::TIMER_W-1:0] r_interval;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir      <= sdm_pkg::DIR_LEFT;
            r_interval <= sdm_pkg::TIMER_W'(250);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == sdm_pkg::REG_DIRECTION) begin
                r_dir <= pwdata[sdm_pkg::DIR_W-1:0];
            end else begin
                r_interval <= pwdata[sdm_pkg::TIMER_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == sdm_pkg::REG_INTERVAL) ? 32'(r_interval) : 32'(r_dir);

    // input fields
    sdm_pkg::t_op                 w_op;
    logic [7:0]                   w_addr;
    logic [7:0]                   w_value;
    logic [sdm_pkg::LEN_W-1:0]    w_len;

    assign w_op    = sdm_pkg::t_op'(i_s_tdata[1:0]);
    assign w_addr  = i_s_tdata[9:2];
    assign w_value = i_s_tdata[17:10];
    assign w_len   = i_s_tdata[26:18];

    // control state
    sdm_pkg::t_mode              r_mode, n_mode;
    logic [sdm_pkg::TIMER_W-1:0] r_timer, n_timer;
    logic [sdm_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [sdm_pkg::LEN_W-1:0]   r_len, n_len;
    logic [sdm_pkg::TIMER_W-1:0] w_tinc;
    logic [sdm_pkg::IDX_W-1:0]   w_back;

    t_s2                          s1;
    t_s2                          r_s2;
    logic                         r_s2_valid;
    logic                         s2_go;
    logic                         s_acc;

    logic                         ram_we;
    logic                         ram_re;
    logic [sdm_pkg::ADDR_W-1:0]   ram_raddr;
    logic [sdm_pkg::CHAR_W-1:0]   ram_rdata;

    logic                         r_out_busy;
    logic [sdm_pkg::POS_W-1:0]    r_out_cnt;
    logic                         out_last;
    logic                         out_hs;
    logic                         out_free;

    sdm_pkg::t_cell_ctl           cell_ctl;
    logic [sdm_pkg::CHAR_W-1:0]   w_enter;
    logic [sdm_pkg::CHAR_W-1:0]   w_disp [sdm_pkg::DIGITS];
    logic [sdm_pkg::CHAR_W-1:0]   w_out  [sdm_pkg::DIGITS];

    assign out_last = (r_out_cnt == sdm_pkg::POS_W'(sdm_pkg::DIGITS - 1));
    assign out_hs   = r_out_busy && i_m_tready;
    assign out_free = !r_out_busy || (out_hs && out_last);
    assign s2_go    = r_s2_valid && (!r_s2.fire || out_free);

    assign o_s_tready = !r_s2_valid || s2_go;
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign w_tinc = (r_timer < sdm_pkg::TIMER_MAX) ? r_timer + 1'b1 : r_timer;
    assign w_back = sdm_pkg::IDX_W'(r_len) - 1'b1 - r_idx;

    always_comb begin
        n_mode    = r_mode;
        n_timer   = r_timer;
        n_idx     = r_idx;
        n_len     = r_len;
        s1        = '0;
        s1.dir    = r_dir;
        ram_we    = 1'b0;
        ram_raddr = (r_dir == sdm_pkg::DIR_RIGHT) ? w_back[sdm_pkg::ADDR_W-1:0]
                                                  : r_idx[sdm_pkg::ADDR_W-1:0];
        if (s_acc) begin
            unique case (w_op)
                sdm_pkg::OP_WRITE: begin
                    ram_we = (int'(w_addr) < sdm_pkg::MSG_DEPTH);
                end
                sdm_pkg::OP_START: begin
                    n_len  = (int'(w_len) > sdm_pkg::MSG_DEPTH) ?
                             sdm_pkg::LEN_W'(sdm_pkg::MSG_DEPTH) : w_len;
                    n_mode = sdm_pkg::M_RESET;
                end
                sdm_pkg::OP_STOP: begin
                    n_mode = sdm_pkg::M_IDLE;
                end
                sdm_pkg::OP_TICK: begin
                    unique case (r_mode)
                        sdm_pkg::M_RESET: begin
                            s1.clear = 1'b1;
                            n_timer  = sdm_pkg::TIMER_MAX;
                            n_idx    = '0;
                            n_mode   = sdm_pkg::M_RUN;
                        end
                        sdm_pkg::M_RUN: begin
                            if (w_tinc < r_interval) begin
                                n_timer = w_tinc;
                            end else begin
                                n_timer = '0;
                                if (r_idx >= sdm_pkg::IDX_W'(r_len)
                                             + sdm_pkg::IDX_W'(sdm_pkg::DIGITS)) begin
                                    n_mode = sdm_pkg::M_RESET;
                                end else begin
                                    s1.fire = 1'b1;
                                    s1.zero = (r_idx >= sdm_pkg::IDX_W'(r_len));
                                    n_idx   = r_idx + 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign ram_re = s1.fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= sdm_pkg::M_IDLE;
            r_timer    <= '0;
            r_idx      <= '0;
            r_len      <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_timer <= n_timer;
            r_idx   <= n_idx;
            r_len   <= n_len;
            if (s_acc) begin
                r_s2_valid <= s1.fire || s1.clear;
            end else if (s2_go) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s2 <= s1;
        end
    end

    sdm_ram #(
        .WIDTH (sdm_pkg::CHAR_W),
        .DEPTH (sdm_pkg::MSG_DEPTH)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (sdm_pkg::ADDR_W'(w_addr)),
        .i_wdata (w_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // cell row control
    assign w_enter = r_s2.zero ? '0 : ram_rdata;

    always_comb begin
        cell_ctl.clear   = s2_go && r_s2.clear;
        cell_ctl.load    = s2_go && r_s2.fire;
        cell_ctl.shift_l = cell_ctl.load && (r_s2.dir == sdm_pkg::DIR_LEFT);
        cell_ctl.shift_r = cell_ctl.load && (r_s2.dir == sdm_pkg::DIR_RIGHT);
        cell_ctl.drain   = out_hs;
    end

    for (genvar j = 0; j < sdm_pkg::DIGITS; j++) begin : g_cell
        logic [sdm_pkg::CHAR_W-1:0] w_left;
        logic [sdm_pkg::CHAR_W-1:0] w_right;
        logic [sdm_pkg::CHAR_W-1:0] w_out_right;

        if (j == 0) begin : g_first
            assign w_left = w_enter;
        end else begin : g_mid_l
            assign w_left = w_disp[j-1];
        end

        if (j == sdm_pkg::DIGITS - 1) begin : g_last
            assign w_right     = w_enter;
            assign w_out_right = '0;
        end else begin : g_mid_r
            assign w_right     = w_disp[j+1];
            assign w_out_right = w_out[j+1];
        end

        sdm_cell u_cell (
            .i_clk            (i_clk),
            .i_ctl            (cell_ctl),
            .i_from_left      (w_left),
            .i_from_right     (w_right),
            .i_out_from_right (w_out_right),
            .o_disp           (w_disp[j]),
            .o_out            (w_out[j])
        );
    end

    // output drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_busy <= 1'b0;
            r_out_cnt  <= '0;
        end else if (cell_ctl.load) begin
            r_out_busy <= 1'b1;
            r_out_cnt  <= '0;
        end else if (out_hs) begin
            r_out_busy <= !out_last;
            r_out_cnt  <= r_out_cnt + 1'b1;
        end
    end

    assign o_m_tvalid = r_out_busy;
    assign o_m_tdata  = {5'b0, w_out[0], r_out_cnt};
    assign o_m_tlast  = out_last;

    `SDM_ASSERT(a_s2_holds, r_s2_valid && r_s2.fire && !out_free |=> r_s2_valid, "firing tick lost while output row busy")
    `SDM_ASSERT(a_drain_ends, o_m_tvalid && o_m_tlast && i_m_tready && !cell_ctl.load |=> !o_m_tvalid, "output still valid after final cell")
    `SDM_ASSERT(a_load_pos0, cell_ctl.load |=> o_m_tvalid && (o_m_tdata[2:0] == 3'd0), "refresh does not start at cell zero")
    `SDM_ASSERT(a_clear_fire, !(r_s2_valid && r_s2.fire && r_s2.clear), "clear and fire in one item")

endmodule

`default_nettype wire
